>>> design/tmad_pkg.sv
// Shared types and constants for the two-axis moving average direction core.
// No dependencies; imported by tmad_axis and the top level.
package tmad_pkg;

    localparam int LIMIT_W  = 16;
    localparam int CENTER_W = 12;

    localparam logic signed [LIMIT_W-1:0] LEFT_LIMIT_RST  = -16'sd10240;
    localparam logic signed [LIMIT_W-1:0] RIGHT_LIMIT_RST = 16'sd10240;
    localparam logic signed [LIMIT_W-1:0] UP_LIMIT_RST    = 16'sd10240;
    localparam logic signed [LIMIT_W-1:0] DOWN_LIMIT_RST  = -16'sd10240;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_LEFT  = 2'd0,
        CFG_RIGHT = 2'd1,
        CFG_UP    = 2'd2,
        CFG_DOWN  = 2'd3
    } tmad_cfg_t;

    // per-cycle pipeline control from the top level to each axis
    typedef struct packed {
        logic accept;   // request taken into the ring this cycle
        logic advance;  // stage-1 request moves to the output register
    } tmad_ctrl_t;

endpackage

>>> design/tmad_axis.sv
// One axis: centering, ring memory with per-entry valid bits, running sum.
// Depends on tmad_pkg (control struct).
module tmad_axis #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12,
    parameter int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmad_pkg::tmad_ctrl_t          ctrl,
    input  logic [SLOT_W-1:0]             slot,
    input  logic [SAMPLE_BITS-1:0]        raw,
    output logic signed [SAMPLE_BITS-1:0] centered,
    output logic signed [SUM_W-1:0]       sum_next
);
    import tmad_pkg::*;

    logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic                          rd_valid_reg;
    logic [WINDOW-1:0]             valid_reg;
    logic signed [SAMPLE_BITS-1:0] cen_in;
    logic signed [SAMPLE_BITS-1:0] cen_reg;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic signed [SUM_W-1:0]       sum_reg;

    // subtracting half scale flips the top bit
    assign cen_in = {~raw[SAMPLE_BITS-1], raw[SAMPLE_BITS-2:0]};

    // read the retiring entry and write the new one at the same slot
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            rd_reg        <= ring_mem[slot];
            ring_mem[slot] <= cen_in;
            cen_reg       <= cen_in;
        end
    end

    // entries never written read as centered zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (ctrl.accept)
        begin
            rd_valid_reg    <= valid_reg[slot];
            valid_reg[slot] <= 1'b1;
        end
    end

    assign old_val  = rd_valid_reg ? rd_reg : '0;
    assign sum_next = sum_reg + SUM_W'(cen_reg) - SUM_W'(old_val);
    assign centered = cen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (ctrl.advance)
            sum_reg <= sum_next;
    end

endmodule

>>> design/two_axis_moving_average_direction_core.sv
// Top level of the two-axis moving average direction core.
// Depends on tmad_pkg and tmad_axis.
//
// Usage:
//   Input channel: in_valid / in_stall carry one request of raw_x, raw_y.
//   Output channel: out_valid / out_stall carry one result per request:
//   centered samples, both window sums and the four direction flags.
//   A request is taken at a clock edge with valid high and stall low.
//   Throughput: one request per cycle while in_stall is low. At accept
//   each axis reads the retiring ring entry into stage 1 and writes the
//   new sample at the same slot of its memory; when stage 1 advances,
//   both are folded into the running sum, the sum is compared with the
//   limits and the output register is loaded.
//   When the receiver stalls, the output holds and one more request is
//   taken into stage 1; after that in_stall rises until the output frees.
//   Reset clears the valid bits of the rings (entries read as zero until
//   written), the sums, the slot counter and the limits to their defaults.
//   No clearing pass is needed; requests are taken right after reset.
//   Limits are written through cfg_we / cfg_index / cfg_data while idle.
module two_axis_moving_average_direction_core #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  tmad_pkg::tmad_cfg_t                    cfg_index,
    input  logic [tmad_pkg::LIMIT_W-1:0]           cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [SAMPLE_BITS-1:0]                 raw_x,
    input  logic [SAMPLE_BITS-1:0]                 raw_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tmad_pkg::CENTER_W-1:0]   centered_x,
    output logic signed [tmad_pkg::CENTER_W-1:0]   centered_y,
    output logic signed [tmad_pkg::LIMIT_W-1:0]    window_sum_x,
    output logic signed [tmad_pkg::LIMIT_W-1:0]    window_sum_y,
    output logic                                   is_left,
    output logic                                   is_right,
    output logic                                   is_up,
    output logic                                   is_down
);
    import tmad_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int CEN_W  = (SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    // limits
    logic signed [LIMIT_W-1:0] left_limit_reg;
    logic signed [LIMIT_W-1:0] right_limit_reg;
    logic signed [LIMIT_W-1:0] up_limit_reg;
    logic signed [LIMIT_W-1:0] down_limit_reg;

    // pipeline control
    logic                  s1_valid_reg;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    tmad_ctrl_t            ctrl;

    // stage-1 data from the axes
    logic signed [SAMPLE_BITS-1:0] cen_x;
    logic signed [SAMPLE_BITS-1:0] cen_y;
    logic signed [SUM_W-1:0]       sum_x_next;
    logic signed [SUM_W-1:0]       sum_y_next;
    logic signed [CMP_W-1:0]       cmp_x;
    logic signed [CMP_W-1:0]       cmp_y;
    logic signed [CEN_W-1:0]       cen_x_ext;
    logic signed [CEN_W-1:0]       cen_y_ext;

    // output register
    logic signed [CENTER_W-1:0] centered_x_reg;
    logic signed [CENTER_W-1:0] centered_y_reg;
    logic signed [LIMIT_W-1:0]  sum_x_reg;
    logic signed [LIMIT_W-1:0]  sum_y_reg;
    logic                       left_reg;
    logic                       right_reg;
    logic                       up_reg;
    logic                       down_reg;

    // stage 1 moves on whenever the output register is free or being drained
    assign ctrl.advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall     = s1_valid_reg && !ctrl.advance;
    assign ctrl.accept  = in_valid && !in_stall;

    assign slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.accept)
                slot_reg <= slot_next;
            if (ctrl.accept)
                s1_valid_reg <= 1'b1;
            else if (ctrl.advance)
                s1_valid_reg <= 1'b0;
            if (ctrl.advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_limit_reg  <= LEFT_LIMIT_RST;
            right_limit_reg <= RIGHT_LIMIT_RST;
            up_limit_reg    <= UP_LIMIT_RST;
            down_limit_reg  <= DOWN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT:  left_limit_reg  <= cfg_data;
                CFG_RIGHT: right_limit_reg <= cfg_data;
                CFG_UP:    up_limit_reg    <= cfg_data;
                CFG_DOWN:  down_limit_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    tmad_axis #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SLOT_W      (SLOT_W),
        .SUM_W       (SUM_W)
    ) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .slot     (slot_reg),
        .raw      (raw_x),
        .centered (cen_x),
        .sum_next (sum_x_next)
    );

    tmad_axis #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SLOT_W      (SLOT_W),
        .SUM_W       (SUM_W)
    ) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .slot     (slot_reg),
        .raw      (raw_y),
        .centered (cen_y),
        .sum_next (sum_y_next)
    );

    // compare at full sum width; limits sign-extended
    assign cmp_x     = CMP_W'(sum_x_next);
    assign cmp_y     = CMP_W'(sum_y_next);
    assign cen_x_ext = CEN_W'(cen_x);
    assign cen_y_ext = CEN_W'(cen_y);

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            centered_x_reg <= cen_x_ext[CENTER_W-1:0];
            centered_y_reg <= cen_y_ext[CENTER_W-1:0];
            sum_x_reg      <= cmp_x[LIMIT_W-1:0];
            sum_y_reg      <= cmp_y[LIMIT_W-1:0];
            left_reg       <= (cmp_x <= CMP_W'(left_limit_reg));
            right_reg      <= (cmp_x >= CMP_W'(right_limit_reg));
            up_reg         <= (cmp_y >= CMP_W'(up_limit_reg));
            down_reg       <= (cmp_y <= CMP_W'(down_limit_reg));
        end
    end

    assign out_valid    = out_valid_reg;
    assign centered_x   = centered_x_reg;
    assign centered_y   = centered_y_reg;
    assign window_sum_x = sum_x_reg;
    assign window_sum_y = sum_y_reg;
    assign is_left      = left_reg;
    assign is_right     = right_reg;
    assign is_up        = up_reg;
    assign is_down      = down_reg;

`ifndef NO_ASSERTIONS
    // back-pressure only with a request parked in stage 1
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall without a stage-1 request");

    // a new result only comes out of stage 1
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a stage-1 request");

    // slot counter stays inside the ring
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_LAST)
        else $error("ring slot out of range");

    // a blocked stage-1 request is not dropped
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("stage-1 request lost under stall");
`endif

endmodule
